// ===== sv/largest_square_in_value_range_defines.svh =====
// Assertion macros shared by the checker of the largest-square block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef LARGEST_SQUARE_IN_VALUE_RANGE_DEFINES_SVH
`define LARGEST_SQUARE_IN_VALUE_RANGE_DEFINES_SVH

// Same-cycle implication.
`define LSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant.
`define LSQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== sv/lsq_pkg.sv =====
// Shared types and constants for the largest-square range query block.
// No dependencies.
package lsq_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam int VAL_W  = 32;  // matrix entry and bound width
  localparam int CFG_W  = 9;   // rows_in_use / cols_in_use width
  localparam int SIDE_W = 9;   // result width
  localparam int IDX_W  = 10;  // search bounds, holds sums of two 9-bit indices

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic [IDX_W-1:0]        n;
    logic [IDX_W-1:0]        m;
  } query_req_t;

  typedef struct packed {
    logic              valid;
    logic [SIDE_W-1:0] side;
  } lsq_res_t;

endpackage

// ===== sv/lsq_mem.sv =====
// Matrix storage: one write port, one read port with registered data.
// Uses lsq_pkg for the entry width.
module lsq_mem #(
  parameter int ROW_W = 8,
  parameter int COL_W = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ROW_W+COL_W-1:0]   wr_addr,
  input  logic [lsq_pkg::VAL_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [ROW_W+COL_W-1:0]   rd_addr,
  output logic [lsq_pkg::VAL_W-1:0] rd_data
);
  import lsq_pkg::*;

  localparam int DEPTH = 1 << (ROW_W + COL_W);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lsq_ctrl.sv =====
// Query sequencer: per row a column bisection, an entry check and a diagonal
// bisection, all through one compare unit and one midpoint adder. Uses lsq_pkg.
module lsq_ctrl #(
  parameter int ROW_W = 8,
  parameter int COL_W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  lsq_pkg::query_req_t       req,
  input  logic                      res_take,
  input  logic [lsq_pkg::VAL_W-1:0] rd_data,
  output logic                      idle,
  output logic                      rd_en,
  output logic [ROW_W+COL_W-1:0]    rd_addr,
  output lsq_pkg::lsq_res_t         res
);
  import lsq_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOOK = 6'b000010,
    ST_CMP  = 6'b000100,
    ST_CHK  = 6'b001000,
    ST_NEXT = 6'b010000,
    ST_DONE = 6'b100000
  } lsq_state_t;

  lsq_state_t state_r, state_nxt;

  logic signed [VAL_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0] n_r, n_nxt, m_r, m_nxt;
  logic [IDX_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic             ph_r, ph_nxt;   // 0: column search, 1: diagonal search

  logic [IDX_W-1:0] sum, mid, row_sel, col_sel, i_inc, rows_left, cols_left;
  logic signed [VAL_W-1:0] thr;
  logic data_lt, data_gt, go_left;

  // shared bisection and compare unit
  always_comb begin
    sum       = a_r + b_r;
    mid       = sum >> 1;
    row_sel   = i_r + (ph_r ? mid : '0);
    col_sel   = (ph_r ? j_r : '0) + mid;
    thr       = (state_r == ST_CMP && !ph_r) ? lo_r : hi_r;
    data_lt   = $signed(rd_data) < thr;
    data_gt   = $signed(rd_data) > thr;
    go_left   = ph_r ? data_gt : !data_lt;
    i_inc     = i_r + IDX_W'(1);
    rows_left = n_r - i_r;
    cols_left = m_r - j_r;
  end

  assign rd_en   = (state_r == ST_LOOK);
  assign rd_addr = {ROW_W'(row_sel), COL_W'(col_sel)};
  assign idle    = (state_r == ST_IDLE);
  assign res.valid = (state_r == ST_DONE);
  assign res.side  = best_r[SIDE_W-1:0];

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    best_nxt  = best_r;
    ph_nxt    = ph_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          lo_nxt   = req.lo;
          hi_nxt   = req.hi;
          n_nxt    = req.n;
          m_nxt    = req.m;
          a_nxt    = '0;
          b_nxt    = req.m;
          i_nxt    = '0;
          best_nxt = '0;
          ph_nxt   = 1'b0;
          state_nxt = (req.n == '0 || req.m == '0) ? ST_DONE : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (a_r != b_r) begin
          state_nxt = ST_CMP;
        end else if (!ph_r) begin
          // read at (i, a) is already in flight since mid equals a
          if (a_r >= m_r) begin
            state_nxt = ST_NEXT;
          end else begin
            j_nxt     = a_r;
            state_nxt = ST_CHK;
          end
        end else begin
          if (a_r > best_r) begin
            best_nxt = a_r;
          end
          state_nxt = ST_NEXT;
        end
      end
      ST_CMP: begin
        if (go_left) begin
          b_nxt = mid;
        end else begin
          a_nxt = mid + IDX_W'(1);
        end
        state_nxt = ST_LOOK;
      end
      ST_CHK: begin
        if (data_gt) begin
          state_nxt = ST_NEXT;
        end else begin
          a_nxt     = '0;
          b_nxt     = (rows_left < cols_left) ? rows_left : cols_left;
          ph_nxt    = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_NEXT: begin
        i_nxt     = i_inc;
        a_nxt     = '0;
        b_nxt     = m_r;
        ph_nxt    = 1'b0;
        state_nxt = (i_inc == n_r) ? ST_DONE : ST_LOOK;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    best_r <= best_nxt;
    ph_r   <= ph_nxt;
  end

endmodule

// ===== sv/largest_square_in_value_range.sv =====
// Largest square of in-range values over a row- and column-sorted matrix.
// Input channel (in_*): cmd 0 loads one entry at (row_index, col_index) and
// gives no result; loads outside MAX_ROWS x MAX_COLS are dropped.
// cmd 1 runs a query with range_low / range_high and gives one best_side.
// Output channel (out_*): one registered result; while the receiver stalls it
// holds, and loads keep being taken until another query is accepted. A
// finished query waits in its last state until the output register is free.
// Query sequence, per active row: a column bisection, an entry check, a
// diagonal bisection when the entry lies in range, and a step to the next
// row; the result is then registered. All of it goes through the single
// read port of the matrix memory and one signed compare unit, with one read
// and one compare per bisection step; in_stall is high for the whole query.
// Configuration: APB writes to rows_in_use (0x0) and cols_in_use (0x4),
// both reset to 1. Reset clears control state only; matrix contents are
// undefined until loaded.
module largest_square_in_value_range #(
  parameter int MAX_ROWS = lsq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lsq_pkg::MAX_COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [7:0]                 in_row_index,
  input  logic [7:0]                 in_col_index,
  input  logic signed [31:0]         in_entry_value,
  input  logic signed [31:0]         in_range_low,
  input  logic signed [31:0]         in_range_high,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lsq_pkg::SIDE_W-1:0] out_best_side,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lsq_pkg::*;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EXT_W = 13;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  logic [CFG_W-1:0] rows_r, cols_r;
  logic             cfg_wr;
  logic             idle, accept, wr_en, res_take, rd_en;
  logic [EXT_W-1:0] wr_row_ext, wr_col_ext;
  logic [ROW_W+COL_W-1:0] rd_addr, wr_addr;
  logic [VAL_W-1:0] rd_data;
  query_req_t       req;
  lsq_res_t         res;
  logic             out_valid_r;
  logic [SIDE_W-1:0] out_side_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_ROWS) ? 32'(rows_r) : 32'(cols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(1);
      cols_r <= CFG_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) begin
        rows_r <= pwdata[CFG_W-1:0];
      end
      if (paddr[2] == REG_COLS) begin
        cols_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  // request intake
  assign in_stall   = !idle;
  assign accept     = in_valid & idle;
  assign wr_row_ext = EXT_W'(in_row_index);
  assign wr_col_ext = EXT_W'(in_col_index);
  assign wr_en      = accept && (in_cmd == CMD_LOAD) &&
                      (wr_row_ext < EXT_W'(MAX_ROWS)) && (wr_col_ext < EXT_W'(MAX_COLS));
  assign wr_addr    = {wr_row_ext[ROW_W-1:0], wr_col_ext[COL_W-1:0]};

  // clamp the register values to the storage size
  assign req.lo = in_range_low;
  assign req.hi = in_range_high;
  assign req.n  = (EXT_W'(rows_r) > EXT_W'(MAX_ROWS)) ? IDX_W'(MAX_ROWS) : IDX_W'(rows_r);
  assign req.m  = (EXT_W'(cols_r) > EXT_W'(MAX_COLS)) ? IDX_W'(MAX_COLS) : IDX_W'(cols_r);

  lsq_mem #(
    .ROW_W(ROW_W),
    .COL_W(COL_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_entry_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lsq_ctrl #(
    .ROW_W(ROW_W),
    .COL_W(COL_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && (in_cmd == CMD_QUERY)),
    .req     (req),
    .res_take(res_take),
    .rd_data (rd_data),
    .idle    (idle),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .res     (res)
  );

  // output register
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      out_side_r <= res.side;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_best_side = out_side_r;

endmodule

// ===== sv/lsq_checker.sv =====
// Port-level checker for the largest-square block, bound to the top level.
// Uses the assertion macros from largest_square_in_value_range_defines.svh.
`include "largest_square_in_value_range_defines.svh"

module lsq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [lsq_pkg::SIDE_W-1:0] out_best_side,
  input logic                       pready
);

  // a stalled result holds
  `LSQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_best_side), "stalled result changed")

  // a load request never makes a result appear
  `LSQ_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && !in_cmd && !out_valid, !out_valid, "load produced a result")

  // a query request keeps the input side busy
  `LSQ_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && in_cmd, in_stall, "query accepted without going busy")

  // a new result comes only out of a running query
  `LSQ_ASSERT_NOW(a_res_src, $rose(out_valid), $past(in_stall), "result without a query in flight")

  `LSQ_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind largest_square_in_value_range lsq_checker u_lsq_checker (.*);

// ===== test/tb_largest_square_in_value_range.sv =====
// Self-checking bench for largest_square_in_value_range: loads sorted matrices,
// runs range queries and checks every best_side against a pinned value or an in-bench predictor.
// Depends on lsq_pkg and the largest_square_in_value_range RTL.
module tb_largest_square_in_value_range;
  timeunit 1ns;
  timeprecision 1ps;
  import lsq_pkg::*;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef enum logic {STEP_REQ, STEP_CFG} step_e;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] row;
    logic [7:0] col;
    val_t       val;
    val_t       lo;
    val_t       hi;
  } req_t;

  typedef struct packed {
    step_e             kind;
    req_t              req;
    logic [2:0]        addr;
    logic [CFG_W-1:0]  data;
    bit                pinned;
    logic [SIDE_W-1:0] side;
  } plan_row_t;

  localparam int MAX_R = MAX_ROWS_DEF;
  localparam int MAX_C = MAX_COLS_DEF;
  localparam logic [2:0] ADDR_ROWS = 3'd0;
  localparam logic [2:0] ADDR_COLS = 3'd4;
  localparam val_t V_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam val_t V_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam longint L_MIN = -64'sd2147483648;
  localparam longint L_MAX = 64'sd2147483647;
  localparam int RAND_ITEMS = 100;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_cmd;
  logic [7:0] in_row_index;
  logic [7:0] in_col_index;
  val_t in_entry_value;
  val_t in_range_low;
  val_t in_range_high;
  logic out_valid;
  logic out_stall;
  logic [SIDE_W-1:0] out_best_side;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  val_t grid [MAX_R][MAX_C];
  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;
  logic [SIDE_W-1:0] side_queue [$];
  plan_row_t dir_plan [$];

  int errors;
  int n_loads;
  int n_queries;
  int n_answers;
  int n_nonzero;
  int widest;
  int n_cfg_writes;
  int burst_left;
  int quiet_cycles;
  bit hold_off_req;

  largest_square_in_value_range u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_entry_value(in_entry_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_best_side (out_best_side),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 30) $display("%0t mismatch: %s", $time, what);
  endtask

  // Per row: bisect for the first column >= lo, then bisect the diagonal run <= hi.
  function automatic logic [SIDE_W-1:0] largest_side(input val_t lo, input val_t hi);
    int unsigned n, m, i, a, b, mid, j, span, best;
    n = (rows_cfg > MAX_R) ? MAX_R : rows_cfg;
    m = (cols_cfg > MAX_C) ? MAX_C : cols_cfg;
    best = 0;
    for (i = 0; i < n; i++) begin
      a = 0;
      b = m;
      while (a != b) begin
        mid = (a + b) >> 1;
        if (grid[i][mid] >= lo) b = mid;
        else a = mid + 1;
      end
      j = a;
      if (j < m && grid[i][j] <= hi) begin
        span = (n - i < m - j) ? n - i : m - j;
        a = 0;
        b = span;
        while (a != b) begin
          mid = (a + b) >> 1;
          if (grid[i + mid][j + mid] > hi) b = mid;
          else a = mid + 1;
        end
        if (a > best) best = a;
      end
    end
    return best[SIDE_W-1:0];
  endfunction

  function automatic val_t clamp_val(input longint v);
    return val_t'((v > L_MAX) ? L_MAX : ((v < L_MIN) ? L_MIN : v));
  endfunction

  function automatic void plan_req(input cmd_t cmd, input logic [7:0] row, input logic [7:0] col,
                                   input val_t val, input val_t lo, input val_t hi,
                                   input bit pinned, input logic [SIDE_W-1:0] side);
    plan_row_t p;
    p = '0;
    p.kind = STEP_REQ;
    p.req.cmd = cmd;
    p.req.row = row;
    p.req.col = col;
    p.req.val = val;
    p.req.lo = lo;
    p.req.hi = hi;
    p.pinned = pinned;
    p.side = side;
    dir_plan.insert(dir_plan.size(), p);
  endfunction

  function automatic void plan_cfg(input logic [2:0] addr, input logic [CFG_W-1:0] data);
    plan_row_t p;
    p = '0;
    p.kind = STEP_CFG;
    p.addr = addr;
    p.data = data;
    dir_plan.insert(dir_plan.size(), p);
  endfunction

  task automatic send_req(input req_t r, input bit pinned, input logic [SIDE_W-1:0] pinned_side);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_row_index <= r.row;
    in_col_index <= r.col;
    in_entry_value <= r.val;
    in_range_low <= r.lo;
    in_range_high <= r.hi;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (r.cmd == CMD_LOAD) begin
      grid[r.row][r.col] = r.val;
      n_loads++;
    end else begin
      side_queue.insert(side_queue.size(), pinned ? pinned_side : largest_side(r.lo, r.hi));
      n_queries++;
    end
  endtask

  task automatic send_load(input int row, input int col, input val_t val);
    req_t r;
    r = '0;
    r.cmd = CMD_LOAD;
    r.row = row[7:0];
    r.col = col[7:0];
    r.val = val;
    send_req(r, 1'b0, '0);
  endtask

  task automatic send_query(input val_t lo, input val_t hi);
    req_t r;
    r = '0;
    r.cmd = CMD_QUERY;
    r.lo = lo;
    r.hi = hi;
    send_req(r, 1'b0, '0);
  endtask

  // Drop valid and wait until every answer is back and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (side_queue.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [CFG_W-1:0] data);
    logic [31:0] rdata;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{(32-CFG_W){1'b0}}, data};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_ROWS) rows_cfg = data;
    else cols_cfg = data;
    n_cfg_writes++;
    if (rdata[CFG_W-1:0] !== data)
      report_mismatch($sformatf("register 0x%0h reads %0d, wrote %0d", addr, rdata, data));
  endtask

  // Fill rows x cols so that rows and columns never decrease.
  task automatic load_sorted(input int rows, input int cols, input longint base);
    longint above [MAX_C];
    longint v, left;
    int r, c;
    for (r = 0; r < rows; r++) begin
      left = L_MIN;
      for (c = 0; c < cols; c++) begin
        if (r == 0 && c == 0) v = base;
        else begin
          v = (r > 0 && above[c] > left) ? above[c] : left;
          v += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 2);
        end
        v = longint'(clamp_val(v));
        above[c] = v;
        left = v;
        send_load(r, c, val_t'(v));
      end
    end
  endtask

  task automatic rand_query(input int rows, input int cols);
    longint lo, hi;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      lo = longint'(val_t'($urandom));
      hi = longint'(val_t'($urandom));
    end else begin
      lo = longint'(grid[$urandom_range(0, rows - 1)][$urandom_range(0, cols - 1)]);
      lo -= $urandom_range(0, 3);
      case (sel)
        1: hi = lo - 1 - $urandom_range(0, 5);
        2: hi = L_MAX;
        3, 4: hi = lo + $urandom_range(0, 100000);
        default: hi = lo + $urandom_range(0, 8);
      endcase
    end
    send_query(clamp_val(lo), clamp_val(hi));
  endtask

  task automatic noise_load();
    send_load($urandom_range(0, 255), $urandom_range(0, 255), val_t'($urandom));
  endtask

  task automatic random_phase(input int phase_no);
    int rows, cols, k, nq;
    longint base;
    rows = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    cols = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    case ($urandom_range(0, 5))
      0: base = L_MIN + $urandom_range(0, 50);
      1: base = L_MAX - $urandom_range(0, 50);
      default: base = longint'($urandom_range(0, 4000)) - 2000;
    endcase
    settle();
    cfg_write(ADDR_ROWS, rows[CFG_W-1:0]);
    cfg_write(ADDR_COLS, cols[CFG_W-1:0]);
    load_sorted(rows, cols, base);
    nq = $urandom_range(5, 10);
    // Let the block back up against a stalled output once.
    if (phase_no == 0) begin
      hold_off_req = 1'b1;
      nq = 12;
    end
    for (k = 0; k < nq; k++) begin
      if ($urandom_range(0, 7) == 0) noise_load();
      rand_query(rows, cols);
    end
  endtask

  always @(posedge clk) begin
    logic [SIDE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (side_queue.size() == 0) begin
        report_mismatch($sformatf("best_side %0d with no query pending", out_best_side));
      end else begin
        want = side_queue.pop_front();
        n_answers++;
        if (out_best_side != 0) n_nonzero++;
        if (out_best_side > widest) widest = out_best_side;
        if (out_best_side !== want)
          report_mismatch($sformatf("best_side %0d, predicted %0d", out_best_side, want));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d answers outstanding",
               quiet_cycles, side_queue.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall segments, plus one long hold-off on request.
  initial begin
    int mode, seg;
    out_stall = 1'b0;
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        seg = $urandom_range(20, 120);
        repeat (seg) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 8);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int k, phase_no, start_items;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_row_index = '0;
    in_col_index = '0;
    in_entry_value = '0;
    in_range_low = '0;
    in_range_high = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rows_cfg = 1;
    cols_cfg = 1;
    burst_left = 0;
    hold_off_req = 1'b0;

    // single entry at reset size, then empty matrices, then a 2x2 with extreme values
    plan_req(CMD_LOAD, 8'd0, 8'd0, 32'sd5, '0, '0, 1'b0, '0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, 32'sd5, 32'sd5, 1'b1, 9'd1);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, 32'sd6, 32'sd100, 1'b1, 9'd0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, 32'sd10, 32'sd3, 1'b1, 9'd0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MIN, V_MAX, 1'b1, 9'd1);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MIN, 32'sd4, 1'b1, 9'd0);
    plan_cfg(ADDR_ROWS, 9'd0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MIN, V_MAX, 1'b1, 9'd0);
    plan_cfg(ADDR_ROWS, 9'd1);
    plan_cfg(ADDR_COLS, 9'd0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MIN, V_MAX, 1'b1, 9'd0);
    plan_cfg(ADDR_ROWS, 9'd2);
    plan_cfg(ADDR_COLS, 9'd2);
    plan_req(CMD_LOAD, 8'd0, 8'd0, V_MIN, '0, '0, 1'b0, '0);
    plan_req(CMD_LOAD, 8'd0, 8'd1, 32'sd0, '0, '0, 1'b0, '0);
    plan_req(CMD_LOAD, 8'd1, 8'd0, 32'sd0, '0, '0, 1'b0, '0);
    plan_req(CMD_LOAD, 8'd1, 8'd1, V_MAX, '0, '0, 1'b0, '0);
    plan_req(CMD_LOAD, 8'd255, 8'd255, -32'sd1, '0, '0, 1'b0, '0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MIN, V_MAX, 1'b1, 9'd2);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MAX, V_MAX, 1'b1, 9'd1);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, 32'sd1, -32'sd1, 1'b1, 9'd0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, 32'sd0, 32'sd0, 1'b0, '0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MIN, 32'sd0, 1'b0, '0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, 32'sd0, V_MAX, 1'b0, '0);

    // over-range sizes: one row at full width, loaded only where the column
    // bisections land, then an empty matrix at full height
    plan_cfg(ADDR_ROWS, 9'd1);
    plan_cfg(ADDR_COLS, 9'd511);
    plan_req(CMD_LOAD, 8'd0, 8'd0, 32'sd100, '0, '0, 1'b0, '0);
    for (k = 1; k <= 128; k = k * 2)
      plan_req(CMD_LOAD, 8'd0, k[7:0], val_t'(100 + k), '0, '0, 1'b0, '0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MIN, V_MAX, 1'b1, 9'd1);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, 32'sd101, V_MAX, 1'b0, '0);
    plan_cfg(ADDR_ROWS, 9'd511);
    plan_cfg(ADDR_COLS, 9'd0);
    plan_req(CMD_QUERY, 8'd0, 8'd0, '0, V_MIN, V_MAX, 1'b1, 9'd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_plan[k]) begin
      if (dir_plan[k].kind == STEP_CFG) begin
        settle();
        cfg_write(dir_plan[k].addr, dir_plan[k].data);
      end else begin
        send_req(dir_plan[k].req, dir_plan[k].pinned, dir_plan[k].side);
      end
    end

    start_items = n_loads + n_queries;
    phase_no = 0;
    while (n_loads + n_queries - start_items < RAND_ITEMS) begin
      random_phase(phase_no);
      phase_no++;
    end

    settle();
    if (side_queue.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", side_queue.size()));
    $display("run: %0d loads, %0d queries, %0d register writes, %0d random phases",
             n_loads, n_queries, n_cfg_writes, phase_no);
    $display("answers: %0d checked, %0d nonzero, widest square %0d, %0d mismatches",
             n_answers, n_nonzero, widest, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
